[rtl/core/rrr_pkg.sv]
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared types and constants for the receive ring reader.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned MIN_FRAME_BYTES = 60;
  localparam int unsigned MAX_FRAME_BYTES = 1518;

  localparam logic [7:0] RESET_START_PAGE = 8'd70;
  localparam logic [7:0] RESET_STOP_PAGE  = 8'd128;

  typedef enum logic {
    OP_START = 1'b0,
    OP_POLL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    OUTCOME_EMPTY = 2'd0,
    OUTCOME_FRAME = 2'd1,
    OUTCOME_BAD   = 2'd2
  } outcome_t;

  typedef enum logic {
    CFG_START_PAGE = 1'b0,
    CFG_STOP_PAGE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  current_write_page;
    logic [7:0]  header_next_page;
    logic [15:0] header_byte_count;
  } item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] payload_address;
    logic [10:0] payload_length;
    logic [10:0] first_segment_length;
    logic [15:0] wrap_address;
    logic [10:0] second_segment_length;
    logic [7:0]  boundary_page;
    logic [7:0]  read_page_after;
  } result_t;

endpackage

[rtl/core/rrr_in_stage.sv]
// ----------------------------------------------------------------------------
// rrr_in_stage
// Input register: holds one word until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module rrr_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrr_pkg::item_t in_item,
  input  logic          take,
  output logic          held_valid,
  output rrr_pkg::item_t held_item
);

  logic           valid;
  rrr_pkg::item_t item;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[rtl/core/rrr_eval.sv]
// ----------------------------------------------------------------------------
// rrr_eval
// Header check, segment split and boundary computation for one word.
// ----------------------------------------------------------------------------
module rrr_eval (
  input  rrr_pkg::item_t   item,
  input  logic [7:0]       read_page,
  input  logic [7:0]       start_page,
  input  logic [7:0]       limit_page,
  output rrr_pkg::result_t result,
  output logic [7:0]       read_page_next
);

  localparam logic [15:0] HdrBytes = 16'(rrr_pkg::HDR_BYTES);
  localparam logic [15:0] CountMin =
    16'(rrr_pkg::HDR_BYTES + rrr_pkg::MIN_FRAME_BYTES);
  localparam logic [15:0] CountMax =
    16'(rrr_pkg::HDR_BYTES + rrr_pkg::MAX_FRAME_BYTES);

  logic [7:0]  restart_page;
  logic        bad;
  logic [15:0] length;
  logic [15:0] address;
  logic [15:0] wrap_limit;
  logic [15:0] to_end;
  logic [15:0] first;
  logic [15:0] second;
  logic [7:0]  boundary;

  assign restart_page = start_page + 8'd1;

  assign bad = (item.header_next_page < start_page) ||
               (item.header_next_page >= limit_page) ||
               (item.header_byte_count < CountMin) ||
               (item.header_byte_count > CountMax);

  assign length     = item.header_byte_count - HdrBytes;
  assign address    = {read_page, 8'd0} + HdrBytes;
  assign wrap_limit = {limit_page, 8'd0};
  assign to_end     = wrap_limit - address;
  assign first      = ((address < wrap_limit) && (to_end < length)) ? to_end : length;
  assign second     = length - first;
  assign boundary   = (item.header_next_page == start_page) ? limit_page - 8'd1
                                                            : item.header_next_page - 8'd1;

  always_comb begin
    result         = '0;
    result.outcome = rrr_pkg::OUTCOME_EMPTY;
    read_page_next = read_page;
    priority if (item.operation == rrr_pkg::OP_START) begin
      read_page_next         = restart_page;
      result.boundary_page   = start_page;
      result.read_page_after = restart_page;
    end else if (item.current_write_page == read_page) begin
      result.read_page_after = read_page;
    end else if (bad) begin
      read_page_next         = restart_page;
      result.outcome         = rrr_pkg::OUTCOME_BAD;
      result.boundary_page   = start_page;
      result.read_page_after = restart_page;
    end else begin
      read_page_next               = item.header_next_page;
      result.outcome               = rrr_pkg::OUTCOME_FRAME;
      result.payload_address       = address;
      result.payload_length        = length[10:0];
      result.first_segment_length  = first[10:0];
      result.wrap_address          = {start_page, 8'd0};
      result.second_segment_length = second[10:0];
      result.boundary_page         = boundary;
      result.read_page_after       = item.header_next_page;
    end
  end

endmodule

[rtl/core/receive_ring_reader.sv]
// ----------------------------------------------------------------------------
// receive_ring_reader
// Walks a paged receive ring one header poll per word and reports the frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries a start or poll word: the chip's
// current write page plus the next-page byte and byte count of the header at
// the read page. Output channel (out_valid/out_ready) returns one result word
// per input word: empty/started, frame (address, length, split at the ring
// wrap, new boundary page) or bad header (ring restarted).
// Ring start and stop pages are written through cfg_we/cfg_index/cfg_data
// by the user only while no word is in flight; the block does not enforce it.
// An accepted word sits in the input register while the evaluation pass
// feeds the result register. Throughput is one word per cycle while
// out_ready stays high; the read page is updated at the same edge the result
// is registered, so the next word already sees it.
// Reset empties both registers, loads start page 70, stop page 128 and read
// page 71. When the receiver stalls, the result register holds its word, the
// input register fills, and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module receive_ring_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  current_write_page,
  input  logic [7:0]  header_next_page,
  input  logic [15:0] header_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [15:0] payload_address,
  output logic [10:0] payload_length,
  output logic [10:0] first_segment_length,
  output logic [15:0] wrap_address,
  output logic [10:0] second_segment_length,
  output logic [7:0]  boundary_page,
  output logic [7:0]  read_page_after
);

  logic [7:0]       start_page;
  logic [7:0]       limit_page;
  logic [7:0]       read_page;
  logic [7:0]       read_page_next;
  rrr_pkg::item_t   in_item;
  rrr_pkg::item_t   held_item;
  logic             held_valid;
  logic             take;
  rrr_pkg::result_t eval_result;
  rrr_pkg::result_t result;
  logic             valid;

  assign in_item.operation          = rrr_pkg::op_t'(operation);
  assign in_item.current_write_page = current_write_page;
  assign in_item.header_next_page   = header_next_page;
  assign in_item.header_byte_count  = header_byte_count;

  assign take = held_valid && (!valid || out_ready);

  rrr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rrr_eval u_eval (
    .item           (held_item),
    .read_page      (read_page),
    .start_page     (start_page),
    .limit_page     (limit_page),
    .result         (eval_result),
    .read_page_next (read_page_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_page <= rrr_pkg::RESET_START_PAGE;
      limit_page <= rrr_pkg::RESET_STOP_PAGE;
    end else if (cfg_we) begin
      unique case (rrr_pkg::cfg_index_t'(cfg_index))
        rrr_pkg::CFG_START_PAGE: start_page <= cfg_data;
        rrr_pkg::CFG_STOP_PAGE:  limit_page <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_page <= rrr_pkg::RESET_START_PAGE + 8'd1;
      valid     <= 1'b0;
    end else begin
      if (take) begin
        read_page <= read_page_next;
      end
      if (take) begin
        valid <= 1'b1;
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= eval_result;
    end
  end

  assign out_valid             = valid;
  assign outcome               = result.outcome;
  assign payload_address       = result.payload_address;
  assign payload_length        = result.payload_length;
  assign first_segment_length  = result.first_segment_length;
  assign wrap_address          = result.wrap_address;
  assign second_segment_length = result.second_segment_length;
  assign boundary_page         = result.boundary_page;
  assign read_page_after       = result.read_page_after;

`ifndef SYNTHESIS
  a_read_page_tracks: assert property (@(posedge clk) disable iff (rst)
    take |=> (read_page == read_page_after))
    else $error("read page differs from reported next read page");

  a_segments_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == rrr_pkg::OUTCOME_FRAME) |->
      (payload_length == 11'(first_segment_length + second_segment_length)))
    else $error("segment lengths do not add up to payload length");

  a_no_frame_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome != rrr_pkg::OUTCOME_FRAME) |->
      (payload_length == 11'd0 && payload_address == 16'd0))
    else $error("frame fields set on a non-frame result");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register is empty");
`endif

endmodule
